>>> sv/uarttx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UART transmit with CTS flow control - shared types
// Beat payloads, queue entry type, CTS tracker codes and FIFO sizing.
// ----------------------------------------------------------------------------
package uarttx_pkg;

  localparam int FIFO_DEPTH = 256;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] put_byte;
  } in_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       dropped;
    logic [1:0] cts_phase;
    logic       tx_waiting;
  } out_t;

  typedef enum logic [1:0] {
    OP_READY = 2'd0,
    OP_CTS   = 2'd1,
    OP_PUT   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CTS_OFF  = 2'd0,
    CTS_ON   = 2'd1,
    CTS_DONE = 2'd2
  } cts_t;

  typedef enum logic [1:0] {
    K_READY,
    K_CTS,
    K_PUT,
    K_NONE
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic {
    BK_FETCH,
    BK_EXEC
  } bk_state_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/uart_transmit_cts_flow_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UART transmit with CTS flow control - top level
// Event beats in (ready, CTS change, put byte), one result beat out per event.
// ----------------------------------------------------------------------------
// Input channel cmd/cmd_valid/cmd_stall carries one event per beat; a
// two-entry front queue decodes and holds events so the input side keeps
// moving while the back end works.
// Output channel rsp/rsp_valid/rsp_stall gives one result per event in order:
// send_valid/send_byte for the transmitter, dropped for a put into a full
// FIFO, the CTS tracker phase and the transmitter waiting flag.
// The back end works through each event in a fetch state, where the
// registered read of the byte FIFO memory gives the head byte, and then in an
// execute state. It takes a new event from the queue only after it has
// executed the last one.
// cfg_we/cfg_data write the flow control enable; write only while idle.
// Reset empties the FIFO, sets CTS to asserted, transmitter not waiting and
// flow control on. FIFO memory needs no clearing pass.
// When rsp_stall is high the result is held; the back end then holds one more
// event and the queue two more before cmd_stall rises.
// ----------------------------------------------------------------------------
module uart_transmit_cts_flow_control
  import uarttx_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_data,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire in_t  cmd,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output out_t      rsp
);

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  uarttx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  uarttx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

>>> sv/uarttx_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UART transmit - front end
// Accepts event beats, decodes the op and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module uarttx_front
  import uarttx_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire in_t  cmd,
  output logic      q_valid,
  output cmd_t      q_cmd,
  input  wire logic q_pop
);

  cmd_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  logic              push;
  cmd_t              dec;

  assign cmd_stall = (cnt == QCNT_W'(QDEPTH));
  assign push      = cmd_valid && !cmd_stall;
  assign q_valid   = (cnt != '0);
  assign q_cmd     = q[rd_ptr];

  always_comb begin
    dec.data = cmd.put_byte;
    case (op_t'(cmd.op))
      OP_READY: dec.kind = K_READY;
      OP_CTS:   dec.kind = K_CTS;
      OP_PUT:   dec.kind = K_PUT;
      default:  dec.kind = K_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      cnt <= cnt + QCNT_W'(push) - QCNT_W'(q_pop);
    end
  end

endmodule
`default_nettype wire

>>> sv/uarttx_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UART transmit - back end
// Byte FIFO memory, CTS tracker, transmitter idle flag and result register.
// ----------------------------------------------------------------------------
module uarttx_back
  import uarttx_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_data,
  input  wire logic q_valid,
  input  wire cmd_t q_cmd,
  output logic      q_pop,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output out_t      rsp
);

  logic [7:0]       mem [FIFO_DEPTH];
  logic [7:0]       rd_data;
  bk_state_t        state, state_next;
  cmd_t             cur, cur_next;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  cts_t             cts, cts_next;
  logic             idle, idle_next;
  logic             fce;
  logic             mem_we;
  logic             may_send;
  logic             sv;
  logic [7:0]       sb;
  logic             dr;
  out_t             rsp_next;
  logic             rsp_valid_next;

  assign may_send = !fce || (cts == CTS_ON);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= cur.data;
    end
    rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fce <= 1'b1;
    end else if (cfg_we) begin
      fce <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_FETCH;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      cts       <= CTS_ON;
      idle      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      cts       <= cts_next;
      idle      <= idle_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    rsp <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    q_pop          = 1'b0;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    cts_next       = cts;
    idle_next      = idle;
    mem_we         = 1'b0;
    sv             = 1'b0;
    sb             = 8'd0;
    dr             = 1'b0;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    case (state)
      BK_FETCH: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cur_next   = q_cmd;
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (!rsp_valid || !rsp_stall) begin
          case (cur.kind)
            K_READY: begin
              if (count != '0 && may_send) begin
                sv         = 1'b1;
                sb         = rd_data;
                head_next  = ptr_inc(head);
                count_next = count - 1'b1;
                cts_next   = CTS_DONE;
                idle_next  = 1'b0;
              end else begin
                idle_next = 1'b1;
              end
            end
            K_CTS: begin
              if (count != '0 && idle && cts == CTS_OFF) begin
                sv         = 1'b1;
                sb         = rd_data;
                head_next  = ptr_inc(head);
                count_next = count - 1'b1;
                cts_next   = CTS_DONE;
                idle_next  = 1'b0;
              end else if (cts == CTS_OFF) begin
                cts_next = CTS_ON;
              end else begin
                cts_next = CTS_OFF;
              end
            end
            K_PUT: begin
              if (idle && may_send) begin
                sv        = 1'b1;
                sb        = cur.data;
                cts_next  = CTS_DONE;
                idle_next = 1'b0;
              end else if (count == CNT_W'(FIFO_DEPTH)) begin
                dr = 1'b1;
              end else begin
                mem_we     = 1'b1;
                tail_next  = ptr_inc(tail);
                count_next = count + 1'b1;
              end
            end
            default: begin
            end
          endcase
          rsp_next.send_valid = sv;
          rsp_next.send_byte  = sb;
          rsp_next.dropped    = dr;
          rsp_next.cts_phase  = cts_next;
          rsp_next.tx_waiting = idle_next;
          rsp_valid_next      = 1'b1;
          state_next          = BK_FETCH;
        end
      end
      default: state_next = BK_FETCH;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("fifo count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> head == tail)
    else $error("empty fifo with unequal pointers");

  a_send_clears_wait: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.send_valid |-> !rsp.tx_waiting && rsp.cts_phase == CTS_DONE)
    else $error("send left transmitter waiting");

  a_drop_no_send: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.dropped |-> !rsp.send_valid)
    else $error("dropped beat also sent");

  a_pop_in_fetch: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == BK_EXEC)
    else $error("queue pop without execute");
`endif

endmodule
`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// UART transmit with CTS flow control - testbench
// Drives event beats (transmitter ready, CTS change, put byte, unused code)
// through a directed table and then random segments: mixed traffic, drain
// runs and long put bursts that can fill the FIFO and force drops. Flow control
// is switched off and on between phases. Every result beat is checked field
// by field against an in-order prediction of the transmit queue and CTS
// tracker, under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import uarttx_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 250;

  typedef struct {
    in_t  ev;
    bit   typed;
    out_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic cmd_valid = 1'b0;
  in_t  cmd = '0;
  logic rsp_stall = 1'b0;
  logic cmd_stall;
  logic rsp_valid;
  out_t rsp;

  logic [7:0]       tx_bytes [FIFO_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] fill;
  cts_t             cts_now;
  logic             tx_idle;
  logic             flow_on;

  out_t results_due [$];
  int   errors = 0;
  int   quiet = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  always #2 clk = ~clk;

  uart_transmit_cts_flow_control dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic in_t mk_ev(input op_t op, input logic [7:0] b);
    in_t e;
    e.op = op;
    e.put_byte = b;
    return e;
  endfunction

  function automatic out_t mk_res(input logic sv, input logic [7:0] sb, input logic dr,
                                  input cts_t ph, input logic w);
    out_t r;
    r.send_valid = sv;
    r.send_byte = sb;
    r.dropped = dr;
    r.cts_phase = ph;
    r.tx_waiting = w;
    return r;
  endfunction

  function automatic void hand_over(inout out_t r, input logic [7:0] b);
    r.send_valid = 1'b1;
    r.send_byte = b;
    cts_now = CTS_DONE;
    tx_idle = 1'b0;
  endfunction

  function automatic logic [7:0] pop_head();
    logic [7:0] b;
    b = tx_bytes[rd_ptr];
    rd_ptr = wrap_inc(rd_ptr);
    fill = fill - 1'b1;
    return b;
  endfunction

  function automatic out_t next_tx_result(input in_t ev);
    out_t r;
    logic clear;
    r = '0;
    clear = !flow_on || cts_now == CTS_ON;
    case (op_t'(ev.op))
      OP_READY: begin
        if (fill != 0 && clear) begin
          hand_over(r, pop_head());
        end else begin
          tx_idle = 1'b1;
        end
      end
      OP_CTS: begin
        if (fill != 0 && tx_idle && cts_now == CTS_OFF) begin
          hand_over(r, pop_head());
        end else if (cts_now == CTS_OFF) begin
          cts_now = CTS_ON;
        end else begin
          cts_now = CTS_OFF;
        end
      end
      OP_PUT: begin
        if (tx_idle && clear) begin
          hand_over(r, ev.put_byte);
        end else if (fill == CNT_W'(FIFO_DEPTH)) begin
          r.dropped = 1'b1;
        end else begin
          tx_bytes[wr_ptr] = ev.put_byte;
          wr_ptr = wrap_inc(wr_ptr);
          fill = fill + 1'b1;
        end
      end
      default: ;
    endcase
    r.cts_phase = cts_now;
    r.tx_waiting = tx_idle;
    return r;
  endfunction

  function automatic in_t rand_ev(input bit draining);
    int r;
    in_t e;
    r = $urandom_range(99);
    e.put_byte = 8'($urandom_range(255));
    if (r < (draining ? 55 : 33)) begin
      e.op = OP_READY;
    end else if (r < (draining ? 90 : 58)) begin
      e.op = OP_CTS;
    end else if (r < 95) begin
      e.op = OP_PUT;
    end else begin
      e.op = OP_NONE;
    end
    return e;
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    errors++;
    $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic push_cmd(input in_t ev, input bit typed, input out_t typed_res);
    logic took;
    out_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= ev;
    do begin
      @(negedge clk);
      took = !cmd_stall;
      @(posedge clk);
    end while (!took);
    pred = next_tx_result(ev);
    results_due.push_back(typed ? typed_res : pred);
  endtask

  task automatic set_flow(input logic v);
    cmd_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    flow_on = v;
  endtask

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(negedge clk) begin : check_rsp
    out_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (results_due.size() == 0) begin
        report("unexpected beat", rsp, 0);
      end else begin
        want = results_due.pop_front();
        if (rsp.send_valid !== want.send_valid)
          report("send_valid", rsp.send_valid, want.send_valid);
        if (rsp.send_byte !== want.send_byte)
          report("send_byte", rsp.send_byte, want.send_byte);
        if (rsp.dropped !== want.dropped)
          report("dropped", rsp.dropped, want.dropped);
        if (rsp.cts_phase !== want.cts_phase)
          report("cts_phase", rsp.cts_phase, want.cts_phase);
        if (rsp.tx_waiting !== want.tx_waiting)
          report("tx_waiting", rsp.tx_waiting, want.tx_waiting);
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    row_t plan [$];
    int   ph;
    int   sent;
    int   len;
    int   pick;
    int   k;
    rd_ptr = '0;
    wr_ptr = '0;
    fill = '0;
    cts_now = CTS_ON;
    tx_idle = 1'b0;
    flow_on = 1'b1;
    plan = '{
      '{mk_ev(OP_NONE,  8'hFF), 1'b1, mk_res(1'b0, 8'h00, 1'b0, CTS_ON,   1'b0)},
      '{mk_ev(OP_PUT,   8'h00), 1'b1, mk_res(1'b0, 8'h00, 1'b0, CTS_ON,   1'b0)},
      '{mk_ev(OP_PUT,   8'hFF), 1'b1, mk_res(1'b0, 8'h00, 1'b0, CTS_ON,   1'b0)},
      '{mk_ev(OP_READY, 8'h00), 1'b1, mk_res(1'b1, 8'h00, 1'b0, CTS_DONE, 1'b0)},
      '{mk_ev(OP_READY, 8'hFF), 1'b1, mk_res(1'b0, 8'h00, 1'b0, CTS_DONE, 1'b1)},
      '{mk_ev(OP_CTS,   8'h00), 1'b1, mk_res(1'b0, 8'h00, 1'b0, CTS_OFF,  1'b1)},
      '{mk_ev(OP_CTS,   8'hFF), 1'b1, mk_res(1'b1, 8'hFF, 1'b0, CTS_DONE, 1'b0)},
      '{mk_ev(OP_CTS,   8'h00), 1'b1, mk_res(1'b0, 8'h00, 1'b0, CTS_OFF,  1'b0)},
      '{mk_ev(OP_CTS,   8'h00), 1'b1, mk_res(1'b0, 8'h00, 1'b0, CTS_ON,   1'b0)},
      '{mk_ev(OP_READY, 8'h00), 1'b1, mk_res(1'b0, 8'h00, 1'b0, CTS_ON,   1'b1)},
      '{mk_ev(OP_READY, 8'h00), 1'b1, mk_res(1'b0, 8'h00, 1'b0, CTS_ON,   1'b1)},
      '{mk_ev(OP_PUT,   8'hA5), 1'b1, mk_res(1'b1, 8'hA5, 1'b0, CTS_DONE, 1'b0)},
      '{mk_ev(OP_PUT,   8'h5A), 1'b1, mk_res(1'b0, 8'h00, 1'b0, CTS_DONE, 1'b0)},
      '{mk_ev(OP_NONE,  8'h00), 1'b1, mk_res(1'b0, 8'h00, 1'b0, CTS_DONE, 1'b0)},
      '{mk_ev(OP_CTS,   8'h00), 1'b1, mk_res(1'b0, 8'h00, 1'b0, CTS_OFF,  1'b0)},
      '{mk_ev(OP_READY, 8'h00), 1'b1, mk_res(1'b0, 8'h00, 1'b0, CTS_OFF,  1'b1)},
      '{mk_ev(OP_PUT,   8'h3C), 1'b0, '0},
      '{mk_ev(OP_CTS,   8'h00), 1'b0, '0},
      '{mk_ev(OP_CTS,   8'h00), 1'b1, mk_res(1'b0, 8'h00, 1'b0, CTS_OFF,  1'b0)},
      '{mk_ev(OP_CTS,   8'h00), 1'b1, mk_res(1'b0, 8'h00, 1'b0, CTS_ON,   1'b0)},
      '{mk_ev(OP_READY, 8'h00), 1'b1, mk_res(1'b1, 8'h3C, 1'b0, CTS_DONE, 1'b0)}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 71;
    foreach (plan[n]) begin
      push_cmd(plan[n].ev, plan[n].typed, plan[n].res);
    end
    for (ph = 0; ph < 6; ph++) begin
      set_flow((ph % 2 == 0) ? 1'b0 : 1'b1);
      send_idle_pct = (ph < 2) ? 8 : ((ph < 4) ? 71 : 0);
      recv_idle_pct = (ph < 2) ? 71 : ((ph < 4) ? 8 : 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = (ph == 0 && sent == 0) ? 0 : $urandom_range(9);
        if (pick == 0) begin
          // burst of puts around the FIFO depth so that puts can start to drop
          len = $urandom_range(250, 280);
          for (k = 0; k < len; k++) begin
            push_cmd(mk_ev(OP_PUT, 8'($urandom_range(255))), 1'b0, '0);
          end
        end else begin
          len = $urandom_range(10, 60);
          for (k = 0; k < len; k++) begin
            push_cmd(rand_ev(pick >= 7), 1'b0, '0);
          end
        end
        sent += len;
      end
    end
    cmd_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
